/* rtl/pip_pkg.sv */
package pip_pkg;

   localparam int COORD_W = 16;
   localparam int FRAC_W = 8;
   localparam int PT_W = COORD_W + FRAC_W;
   localparam int WORLD_W = 33;
   localparam int DIFF_W = 35;
   localparam int SPLIT = 18;
   localparam int MUL_W = 19;
   localparam int PROD_W = 2 * MUL_W;
   localparam int ACC_W = 72;
   localparam int PP_STEPS = 8;
   localparam int STEP_W = 3;
   localparam int RAM_W = 2 * COORD_W;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      KIND_CLEAR  = 2'd0,
      KIND_APPEND = 2'd1,
      KIND_QUERY  = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      REG_SCALE_X  = 2'd0,
      REG_SCALE_Y  = 2'd1,
      REG_OFFSET_X = 2'd2,
      REG_OFFSET_Y = 2'd3
   } reg_idx_type;

   typedef struct packed {
      logic [COORD_W-1:0]        scale_x;
      logic [COORD_W-1:0]        scale_y;
      logic signed [COORD_W-1:0] offset_x;
      logic signed [COORD_W-1:0] offset_y;
   } cfg_type;

   typedef struct packed {
      logic load_item;
      logic decode;
      logic fetch;
      logic world_x_mul;
      logic world_y_mul;
      logic world_x_add;
      logic world_y_add;
      logic advance;
      logic close;
      logic edge_setup;
      logic mul_step;
      logic decide;
      logic reply;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_query;
      logic count_zero;
      logic idx_first;
      logic idx_last;
      logic hit;
      logic step_last;
   } ctrl_sts_type;

endpackage

/* rtl/pip_if.sv */
interface pip_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic signed [15:0] coord_x;
   logic signed [15:0] coord_y;

   modport source (output valid, output kind, output coord_x, output coord_y, input ready);
   modport sink (input valid, input kind, input coord_x, input coord_y, output ready);
endinterface

interface pip_rsp_if;
   logic valid;
   logic ready;
   logic inside_res;
   logic status;

   modport source (output valid, output inside_res, output status, input ready);
   modport sink (input valid, input inside_res, input status, output ready);
endinterface

/* rtl/pip_ram.sv */
module pip_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/pip_csr.sv */
module pip_csr
   import pip_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output cfg_type               cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   reg_idx_type reg_idx;

   assign reg_idx = reg_idx_type'(paddr[CSR_ADDR_W-1:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         unique case (reg_idx)
            REG_SCALE_X:  cfg_in.scale_x = pwdata[COORD_W-1:0];
            REG_SCALE_Y:  cfg_in.scale_y = pwdata[COORD_W-1:0];
            REG_OFFSET_X: cfg_in.offset_x = pwdata[COORD_W-1:0];
            REG_OFFSET_Y: cfg_in.offset_y = pwdata[COORD_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scale_x <= COORD_W'(256);
         cfg_ff.scale_y <= COORD_W'(256);
         cfg_ff.offset_x <= '0;
         cfg_ff.offset_y <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_SCALE_X:  prdata = {{(CSR_DATA_W-COORD_W){1'b0}}, cfg_ff.scale_x};
         REG_SCALE_Y:  prdata = {{(CSR_DATA_W-COORD_W){1'b0}}, cfg_ff.scale_y};
         REG_OFFSET_X: prdata = {{(CSR_DATA_W-COORD_W){1'b0}}, cfg_ff.offset_x};
         REG_OFFSET_Y: prdata = {{(CSR_DATA_W-COORD_W){1'b0}}, cfg_ff.offset_y};
      endcase
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/pip_ctrl.sv */
module pip_ctrl
   import pip_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output ctrl_cmd_type cmd,
   input  ctrl_sts_type sts
);

   typedef enum logic [12:0] {
      S_IDLE    = 13'b0000000000001,
      S_DECODE  = 13'b0000000000010,
      S_FETCH   = 13'b0000000000100,
      S_WX      = 13'b0000000001000,
      S_WY      = 13'b0000000010000,
      S_WADD    = 13'b0000000100000,
      S_ADVANCE = 13'b0000001000000,
      S_CLOSE   = 13'b0000010000000,
      S_SETUP   = 13'b0000100000000,
      S_MUL     = 13'b0001000000000,
      S_ACCL    = 13'b0010000000000,
      S_DECIDE  = 13'b0100000000000,
      S_REPLY   = 13'b1000000000000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      closing_ff;
   logic      closing_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      closing_in = closing_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready = 1'b0;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            closing_in = 1'b0;
            if (sts.is_query && !sts.count_zero) begin
               state_in = S_FETCH;
            end else begin
               state_in = S_REPLY;
            end
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in = S_WX;
         end
         S_WX: begin
            cmd.world_x_mul = 1'b1;
            state_in = S_WY;
         end
         S_WY: begin
            cmd.world_x_add = 1'b1;
            cmd.world_y_mul = 1'b1;
            state_in = S_WADD;
         end
         S_WADD: begin
            cmd.world_y_add = 1'b1;
            state_in = sts.idx_first ? S_ADVANCE : S_SETUP;
         end
         S_ADVANCE: begin
            cmd.advance = 1'b1;
            state_in = sts.idx_last ? S_CLOSE : S_FETCH;
         end
         S_CLOSE: begin
            cmd.close = 1'b1;
            closing_in = 1'b1;
            state_in = S_SETUP;
         end
         S_SETUP: begin
            cmd.edge_setup = 1'b1;
            if (sts.hit) begin
               state_in = S_MUL;
            end else begin
               state_in = closing_ff ? S_REPLY : S_ADVANCE;
            end
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            if (sts.step_last) begin
               state_in = S_ACCL;
            end
         end
         S_ACCL: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in = closing_ff ? S_REPLY : S_ADVANCE;
         end
         S_REPLY: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.reply = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         closing_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         closing_ff <= closing_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/pip_dpath.sv */
module pip_dpath
   import pip_pkg::*;
#(
   parameter int MAX_VERTICES = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cfg_type                   cfg,
   input  logic [1:0]                req_kind,
   input  logic signed [COORD_W-1:0] req_coord_x,
   input  logic signed [COORD_W-1:0] req_coord_y,
   output logic                      rsp_inside_res,
   output logic                      rsp_status,
   input  ctrl_cmd_type              cmd,
   output ctrl_sts_type              sts
);

   localparam int IDX_W = $clog2(MAX_VERTICES);
   localparam int COUNT_W = $clog2(MAX_VERTICES + 1);
   localparam int OFF_PAD = WORLD_W - PT_W;
   localparam int HI_PAD = MUL_W - (DIFF_W - SPLIT);
   localparam int LO_PAD = MUL_W - SPLIT;
   localparam int LOC_PAD = MUL_W - COORD_W;

   kind_type                  kind_ff;
   logic signed [COORD_W-1:0] cx_ff;
   logic signed [COORD_W-1:0] cy_ff;
   logic [COUNT_W-1:0]        count_ff;
   logic [COUNT_W-1:0]        count_in;
   logic [IDX_W-1:0]          idx_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [WORLD_W-1:0] p1x_ff, p1y_ff, p2x_ff, p2y_ff, fx_ff, fy_ff;
   logic signed [DIFF_W-1:0]  a_ff, b_ff, c_ff, d_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic                      pp_vld_ff;
   logic [STEP_W-1:0]         pp_step_ff;
   logic [STEP_W-1:0]         step_ff;
   logic                      inside_ff;
   logic                      drop_ff;
   logic                      rsp_inside_ff;
   logic                      rsp_status_ff;

   logic                      full;
   logic                      ram_we;
   logic [RAM_W-1:0]          ram_rdata;
   logic signed [COORD_W-1:0] loc_x, loc_y;
   logic signed [PT_W-1:0]    px_s, py_s;
   logic signed [WORLD_W-1:0] wprod, offx_w, offy_w;
   logic signed [MUL_W-1:0]   mul_a, mul_b;
   logic signed [PROD_W-1:0]  mul_p;
   logic signed [DIFF_W-1:0]  op_x, op_y;
   logic signed [ACC_W-1:0]   pp_ext, pp_sh;
   logic                      toggle;

   assign full = (count_ff == COUNT_W'(MAX_VERTICES));
   assign ram_we = cmd.decode && (kind_ff == KIND_APPEND) && !full;
   assign loc_x = ram_rdata[RAM_W-1:COORD_W];
   assign loc_y = ram_rdata[COORD_W-1:0];
   assign px_s = {cx_ff, {FRAC_W{1'b0}}};
   assign py_s = {cy_ff, {FRAC_W{1'b0}}};
   assign wprod = prod_ff[WORLD_W-1:0];
   assign offx_w = {{OFF_PAD{cfg.offset_x[COORD_W-1]}}, cfg.offset_x, {FRAC_W{1'b0}}};
   assign offy_w = {{OFF_PAD{cfg.offset_y[COORD_W-1]}}, cfg.offset_y, {FRAC_W{1'b0}}};

   pip_ram #(
      .WIDTH(RAM_W),
      .DEPTH(MAX_VERTICES)
   ) u_store (
      .clock(clock),
      .wr_en(ram_we),
      .wr_addr(count_ff[IDX_W-1:0]),
      .wr_data({cx_ff, cy_ff}),
      .rd_en(cmd.fetch),
      .rd_addr(idx_ff),
      .rd_data(ram_rdata)
   );

   always_comb begin
      op_x = step_ff[2] ? c_ff : a_ff;
      op_y = step_ff[2] ? d_ff : b_ff;
      if (cmd.world_x_mul) begin
         mul_a = {{LOC_PAD{loc_x[COORD_W-1]}}, loc_x};
         mul_b = {{LOC_PAD{1'b0}}, cfg.scale_x};
      end else if (cmd.world_y_mul) begin
         mul_a = {{LOC_PAD{loc_y[COORD_W-1]}}, loc_y};
         mul_b = {{LOC_PAD{1'b0}}, cfg.scale_y};
      end else begin
         if (step_ff[1]) begin
            mul_a = {{LO_PAD{1'b0}}, op_x[SPLIT-1:0]};
         end else begin
            mul_a = {{HI_PAD{op_x[DIFF_W-1]}}, op_x[DIFF_W-1:SPLIT]};
         end
         if (step_ff[0]) begin
            mul_b = {{LO_PAD{1'b0}}, op_y[SPLIT-1:0]};
         end else begin
            mul_b = {{HI_PAD{op_y[DIFF_W-1]}}, op_y[DIFF_W-1:SPLIT]};
         end
      end
   end

   assign mul_p = mul_a * mul_b;

   always_comb begin
      pp_ext = ACC_W'(prod_ff);
      case (pp_step_ff[1:0]) inside
         2'd0:       pp_sh = pp_ext <<< (2 * SPLIT);
         2'd1, 2'd2: pp_sh = pp_ext <<< SPLIT;
         default:    pp_sh = pp_ext;
      endcase
   end

   always_comb begin
      if (b_ff[DIFF_W-1]) begin
         toggle = acc_ff[ACC_W-1];
      end else begin
         toggle = !acc_ff[ACC_W-1] && (acc_ff != '0);
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.decode) begin
         case (kind_ff)
            KIND_CLEAR:  count_in = '0;
            KIND_APPEND: count_in = full ? count_ff : count_ff + COUNT_W'(1);
            default:     count_in = count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pp_vld_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         pp_vld_ff <= cmd.mul_step;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         kind_ff <= kind_type'(req_kind);
         cx_ff <= req_coord_x;
         cy_ff <= req_coord_y;
      end
      if (cmd.decode) begin
         idx_ff <= '0;
         inside_ff <= 1'b0;
         drop_ff <= (kind_ff == KIND_APPEND) && full;
      end else if (cmd.advance) begin
         idx_ff <= idx_ff + IDX_W'(1);
      end
      if (cmd.world_x_mul || cmd.world_y_mul || cmd.mul_step) begin
         prod_ff <= mul_p;
      end
      if (cmd.world_x_add) begin
         p2x_ff <= wprod + offx_w;
      end
      if (cmd.world_y_add) begin
         p2y_ff <= wprod + offy_w;
      end
      if (cmd.advance) begin
         p1x_ff <= p2x_ff;
         p1y_ff <= p2y_ff;
         if (idx_ff == '0) begin
            fx_ff <= p2x_ff;
            fy_ff <= p2y_ff;
         end
      end
      if (cmd.close) begin
         p2x_ff <= fx_ff;
         p2y_ff <= fy_ff;
      end
      if (cmd.edge_setup) begin
         a_ff <= DIFF_W'(px_s) - DIFF_W'(p1x_ff);
         b_ff <= DIFF_W'(p2y_ff) - DIFF_W'(p1y_ff);
         c_ff <= DIFF_W'(p2x_ff) - DIFF_W'(p1x_ff);
         d_ff <= DIFF_W'(py_s) - DIFF_W'(p1y_ff);
         acc_ff <= '0;
         step_ff <= '0;
      end else begin
         if (cmd.mul_step) begin
            step_ff <= step_ff + STEP_W'(1);
            pp_step_ff <= step_ff;
         end
         if (pp_vld_ff) begin
            acc_ff <= pp_step_ff[2] ? acc_ff - pp_sh : acc_ff + pp_sh;
         end
      end
      if (cmd.decide && toggle) begin
         inside_ff <= !inside_ff;
      end
      if (cmd.reply) begin
         rsp_inside_ff <= inside_ff;
         rsp_status_ff <= drop_ff;
      end
   end

   assign sts.is_query = (kind_ff == KIND_QUERY);
   assign sts.count_zero = (count_ff == '0);
   assign sts.idx_first = (idx_ff == '0);
   assign sts.idx_last = ((COUNT_W'(idx_ff) + COUNT_W'(1)) == count_ff);
   assign sts.hit = ((p1y_ff <= py_s) && (py_s < p2y_ff)) ||
                    ((p2y_ff <= py_s) && (py_s < p1y_ff));
   assign sts.step_last = (step_ff == STEP_W'(PP_STEPS - 1));

   assign rsp_inside_res = rsp_inside_ff;
   assign rsp_status = rsp_status_ff;

endmodule

/* rtl/point_in_polygon_test_unit.sv */
// Channel   Direction  Handshake               Payload
// req_chan  in         valid/ready transfer    kind, coord_x, coord_y
// rsp_chan  out        valid/ready transfer    inside_res, status
// csr_*     in         APB write, pready high  scale_x, scale_y, offset_x, offset_y
//
// Clear, append and unused kinds pass through the decode and reply states to the result.
// A query fetches, maps and advances over each vertex, with an edge comparison
// for each edge that straddles the point's row; one shared 19x19 multiplier
// forms the vertex mapping and eight partial products of the exact comparison.
// Reset restores the register defaults and empties the polygon; the vertex
// memory is not cleared.
// One item is taken while a result waits; the block then holds until rsp_chan
// completes a transfer.
module point_in_polygon_test_unit
   import pip_pkg::*;
#(
   parameter int MAX_VERTICES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   pip_req_if.sink               req_chan,
   pip_rsp_if.source             rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type      cfg;
   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   assign csr_pready = 1'b1;

   pip_csr u_csr (
      .clock(clock),
      .reset(reset),
      .psel(csr_psel),
      .penable(csr_penable),
      .pwrite(csr_pwrite),
      .paddr(csr_paddr),
      .pwdata(csr_pwdata),
      .prdata(csr_prdata),
      .cfg(cfg)
   );

   pip_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_chan.valid),
      .req_ready(req_chan.ready),
      .rsp_valid(rsp_chan.valid),
      .rsp_ready(rsp_chan.ready),
      .cmd(cmd),
      .sts(sts)
   );

   pip_dpath #(
      .MAX_VERTICES(MAX_VERTICES)
   ) u_dpath (
      .clock(clock),
      .reset(reset),
      .cfg(cfg),
      .req_kind(req_chan.kind),
      .req_coord_x(req_chan.coord_x),
      .req_coord_y(req_chan.coord_y),
      .rsp_inside_res(rsp_chan.inside_res),
      .rsp_status(rsp_chan.status),
      .cmd(cmd),
      .sts(sts)
   );

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps

module testbench
   import pip_pkg::*;
();

   localparam int VERTEX_SLOTS = 16;
   localparam int QUIET_LIMIT = 4000;
   localparam int HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES = 300;

   class polygon_tracker #(int SLOTS = 16);
      typedef struct packed {
         logic inside_res;
         logic status;
      } reply_type;

      logic [15:0]        scale_x;
      logic [15:0]        scale_y;
      logic signed [15:0] offset_x;
      logic signed [15:0] offset_y;
      logic signed [15:0] local_x [SLOTS];
      logic signed [15:0] local_y [SLOTS];
      int unsigned        vertex_total;
      reply_type          pending_replies [$];
      int                 mismatches;

      function new();
         scale_x = 16'd256;
         scale_y = 16'd256;
         offset_x = '0;
         offset_y = '0;
         vertex_total = 0;
         mismatches = 0;
      endfunction

      function void set_reg(reg_idx_type idx, logic [15:0] value);
         case (idx)
            REG_SCALE_X:  scale_x = value;
            REG_SCALE_Y:  scale_y = value;
            REG_OFFSET_X: offset_x = value;
            REG_OFFSET_Y: offset_y = value;
            default: ;
         endcase
      endfunction

      function logic signed [79:0] to_world(logic signed [15:0] loc, logic [15:0] sc,
                                            logic signed [15:0] off);
         logic signed [79:0] l;
         logic signed [79:0] s;
         logic signed [79:0] o;
         l = loc;
         s = {64'd0, sc};
         o = off;
         return l * s + o * 80'sd256;
      endfunction

      function bit point_inside(logic signed [15:0] qx, logic signed [15:0] qy);
         logic signed [79:0] px;
         logic signed [79:0] py;
         logic signed [79:0] x1;
         logic signed [79:0] y1;
         logic signed [79:0] x2;
         logic signed [79:0] y2;
         logic signed [79:0] lhs;
         logic signed [79:0] rhs;
         int unsigned        j;
         bit                 in_poly;
         px = qx;
         py = qy;
         px = px * 80'sd256;
         py = py * 80'sd256;
         in_poly = 0;
         for (int unsigned i = 0; i < vertex_total; i++) begin
            j = (i + 1 < vertex_total) ? i + 1 : 0;
            x1 = to_world(local_x[i], scale_x, offset_x);
            y1 = to_world(local_y[i], scale_y, offset_y);
            x2 = to_world(local_x[j], scale_x, offset_x);
            y2 = to_world(local_y[j], scale_y, offset_y);
            if (y1 != y2 && ((y1 <= py && py < y2) || (y2 <= py && py < y1))) begin
               lhs = (px - x1) * (y2 - y1);
               rhs = (x2 - x1) * (py - y1);
               if ((y2 > y1 && lhs > rhs) || (y2 < y1 && lhs < rhs)) begin
                  in_poly = !in_poly;
               end
            end
         end
         return in_poly;
      endfunction

      function void note_item(kind_type k, logic signed [15:0] x, logic signed [15:0] y);
         reply_type r;
         r = '0;
         case (k)
            KIND_CLEAR: begin
               vertex_total = 0;
            end
            KIND_APPEND: begin
               if (vertex_total < SLOTS) begin
                  local_x[vertex_total] = x;
                  local_y[vertex_total] = y;
                  vertex_total++;
               end else begin
                  r.status = 1'b1;
               end
            end
            KIND_QUERY: begin
               r.inside_res = point_inside(x, y);
            end
            default: ;
         endcase
         pending_replies = {pending_replies, r};
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         mismatches++;
      endtask

      task check_result(logic inside_res, logic status);
         reply_type want;
         if (pending_replies.size() == 0) begin
            report_mismatch($sformatf("unexpected transfer inside_res=%0b status=%0b",
                                      inside_res, status));
         end else begin
            want = pending_replies.pop_front();
            if (inside_res !== want.inside_res) begin
               report_mismatch($sformatf("inside_res expected %0b got %0b",
                                         want.inside_res, inside_res));
            end
            if (status !== want.status) begin
               report_mismatch($sformatf("status expected %0b got %0b",
                                         want.status, status));
            end
         end
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   pip_req_if req_bus ();
   pip_rsp_if rsp_bus ();

   polygon_tracker #(VERTEX_SLOTS) tracker;

   int req_idle_pct;
   int rsp_idle_pct;
   int hold_left;
   bit hold_pending;
   int quiet_cycles;

   point_in_polygon_test_unit #(
      .MAX_VERTICES(VERTEX_SLOTS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic signed [15:0] to_coord(longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return 16'(v);
   endfunction

   task automatic send_item(kind_type k, logic signed [15:0] x, logic signed [15:0] y);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.kind <= k;
      req_bus.coord_x <= x;
      req_bus.coord_y <= y;
      do @(posedge clock); while (!req_bus.ready);
      tracker.note_item(k, x, y);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending_replies.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(reg_idx_type idx, logic [15:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      if (idx == REG_OFFSET_X || idx == REG_OFFSET_Y) begin
         csr_pwdata <= {{16{value[15]}}, value};
      end else begin
         csr_pwdata <= {16'd0, value};
      end
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      tracker.set_reg(idx, value);
      @(posedge clock);
   endtask

   task automatic apply_setting(int p);
      logic [15:0] v [4];
      case (p)
         0: v = '{16'd256, 16'd256, 16'd0, 16'd0};
         1: v = '{16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000};
         2: v = '{16'd0, 16'd256, 16'h8000, 16'h7FFF};
         3: v = '{16'd128, 16'd384, 16'($urandom_range(400)) - 16'd200,
                  16'($urandom_range(400)) - 16'd200};
         4: v = '{16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom())};
         default: v = '{16'd256, 16'd0, 16'd0, 16'd0};
      endcase
      csr_write(REG_SCALE_X, v[0]);
      csr_write(REG_SCALE_Y, v[1]);
      csr_write(REG_OFFSET_X, v[2]);
      csr_write(REG_OFFSET_Y, v[3]);
   endtask

   task automatic run_directed();
      send_item(KIND_QUERY, 16'sd0, 16'sd0);
      send_item(KIND_APPEND, 16'sd5, 16'sd5);
      send_item(KIND_QUERY, 16'sd5, 16'sd5);
      send_item(KIND_CLEAR, 16'sh7FFF, 16'sh8000);
      send_item(KIND_APPEND, 16'sd0, 16'sd0);
      send_item(KIND_APPEND, 16'sd100, 16'sd0);
      send_item(KIND_APPEND, 16'sd100, 16'sd100);
      send_item(KIND_APPEND, 16'sd0, 16'sd100);
      send_item(KIND_QUERY, 16'sd50, 16'sd50);
      send_item(KIND_QUERY, 16'sd0, 16'sd0);
      send_item(KIND_QUERY, 16'sd100, 16'sd100);
      send_item(KIND_NONE, 16'sh7FFF, 16'sh8000);
      for (int k = 0; k < VERTEX_SLOTS - 4; k++) begin
         send_item(KIND_APPEND, k[0] ? 16'sh7FFF : 16'sh8000, k[1] ? 16'sh8000 : 16'sh7FFF);
      end
      send_item(KIND_APPEND, 16'sh7FFF, 16'sh7FFF);
      send_item(KIND_QUERY, 16'sh8000, 16'sh7FFF);
      send_item(KIND_QUERY, 16'sd50, 16'sd20);
   endtask

   task automatic run_random(int n_items, bit with_hold);
      int         sent;
      int         r;
      int         nv;
      int         nq;
      int         span;
      int         pick;
      bit         hold_issued;
      longint     cx0;
      longint     cy0;
      longint     wx;
      longint     wy;
      int         lo_x;
      int         hi_x;
      int         lo_y;
      int         hi_y;
      longint     world_xs [$];
      longint     world_ys [$];
      logic signed [15:0] lx;
      logic signed [15:0] ly;
      logic signed [15:0] qx;
      logic signed [15:0] qy;
      logic signed [15:0] cw;
      kind_type   k;
      sent = 0;
      hold_issued = 0;
      repeat (3) begin
         send_item(KIND_QUERY, 16'($urandom_range(400)) - 16'sd200,
                   16'($urandom_range(400)) - 16'sd200);
         sent++;
      end
      while (sent < n_items) begin
         if (with_hold && !hold_issued && sent >= n_items / 3) begin
            hold_pending = 1'b1;
            hold_issued = 1'b1;
         end
         r = $urandom_range(99);
         if (r < 85) begin
            send_item(KIND_CLEAR, 16'($urandom()), 16'($urandom()));
            sent++;
            r = $urandom_range(99);
            nv = (r < 8) ? $urandom_range(2) : ((r < 20) ? $urandom_range(19, 16)
                                                         : $urandom_range(15, 3));
            case ($urandom_range(3))
               0: span = 6;
               1: span = 60;
               2: span = 1500;
               default: span = 32767;
            endcase
            cx0 = (span == 32767) ? 0 : longint'($urandom_range(400)) - 200;
            cy0 = (span == 32767) ? 0 : longint'($urandom_range(400)) - 200;
            world_xs.delete();
            world_ys.delete();
            for (int i = 0; i < nv; i++) begin
               lx = to_coord(cx0 + longint'($urandom_range(2 * span)) - span);
               ly = to_coord(cy0 + longint'($urandom_range(2 * span)) - span);
               send_item(KIND_APPEND, lx, ly);
               sent++;
               if (world_xs.size() < VERTEX_SLOTS) begin
                  wx = ((longint'(lx) * longint'(tracker.scale_x)) >>> 8)
                       + longint'(tracker.offset_x);
                  wy = ((longint'(ly) * longint'(tracker.scale_y)) >>> 8)
                       + longint'(tracker.offset_y);
                  world_xs = {world_xs, wx};
                  world_ys = {world_ys, wy};
               end
            end
            lo_x = 0;
            hi_x = 0;
            lo_y = 0;
            hi_y = 0;
            foreach (world_xs[i]) begin
               cw = to_coord(world_xs[i]);
               if (i == 0 || cw < lo_x) lo_x = int'(cw);
               if (i == 0 || cw > hi_x) hi_x = int'(cw);
               cw = to_coord(world_ys[i]);
               if (i == 0 || cw < lo_y) lo_y = int'(cw);
               if (i == 0 || cw > hi_y) hi_y = int'(cw);
            end
            nq = $urandom_range(8, 1);
            for (int q = 0; q < nq; q++) begin
               r = $urandom_range(99);
               if (r < 25 && world_xs.size() > 0) begin
                  pick = $urandom_range(world_xs.size() - 1);
                  qx = to_coord(world_xs[pick]
                                + ((r < 10) ? 0 : longint'($urandom_range(2)) - 1));
                  pick = $urandom_range(world_xs.size() - 1);
                  qy = to_coord(world_ys[pick]
                                + ((r < 15) ? 0 : longint'($urandom_range(2)) - 1));
               end else if (r < 90) begin
                  qx = to_coord(longint'(lo_x) - 2 + longint'($urandom_range(hi_x - lo_x + 4)));
                  qy = to_coord(longint'(lo_y) - 2 + longint'($urandom_range(hi_y - lo_y + 4)));
               end else begin
                  qx = 16'($urandom());
                  qy = 16'($urandom());
               end
               send_item(KIND_QUERY, qx, qy);
               sent++;
            end
            if ($urandom_range(9) == 0) begin
               send_item(KIND_NONE, 16'($urandom()), 16'($urandom()));
            end
         end else begin
            k = kind_type'(2'($urandom()));
            send_item(k, 16'($urandom()), 16'($urandom()));
            if (k != KIND_NONE) sent++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            tracker.check_result(rsp_bus.inside_res, rsp_bus.status);
         end
         if (hold_pending && hold_left == 0) begin
            hold_left = HOLD_CYCLES;
            hold_pending = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      tracker = new();
      req_idle_pct = 26;
      rsp_idle_pct = 51;
      hold_left = 0;
      hold_pending = 1'b0;
      quiet_cycles = 0;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.kind <= KIND_CLEAR;
      req_bus.coord_x <= '0;
      req_bus.coord_y <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      for (int p = 0; p < 6; p++) begin
         drain();
         apply_setting(p);
         if (p < 2) begin
            req_idle_pct = 26;
            rsp_idle_pct = 51;
         end else if (p < 4) begin
            req_idle_pct = 51;
            rsp_idle_pct = 26;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         run_random(200, p == 0);
      end
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
